### rtl/plot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plot_pkg;

   // Field widths of the request and response transactions
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int ID_W        = 32;
   localparam int SIZE_W      = 32;
   localparam int VOL_W       = 32;
   localparam int COUNT_OUT_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_MODIFY = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_DUP     = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // One stored order
   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] size;
   } entry_type;

   // Response payload
   typedef struct packed {
      status_type              status;
      logic [VOL_W-1:0]        total_volume;
      logic [COUNT_OUT_W-1:0]  order_count;
   } result_type;

endpackage

`default_nettype wire

### rtl/plot_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel
interface plot_req_if import plot_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [ID_W-1:0]   order_id;
   logic [SIZE_W-1:0] order_size;

   modport source (output valid, output cmd, output order_id, output order_size,
                   input ready);
   modport sink   (input valid, input cmd, input order_id, input order_size,
                   output ready);
endinterface

// Response channel
interface plot_rsp_if import plot_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [VOL_W-1:0]       total_volume;
   logic [COUNT_OUT_W-1:0] order_count;

   modport source (output valid, output status, output total_volume, output order_count,
                   input ready);
   modport sink   (input valid, input status, input total_volume, input order_count,
                   output ready);
endinterface

`default_nettype wire

### rtl/plot_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Order entry store: one write port, one read port, registered read data
module plot_ram import plot_pkg::*; #(
   parameter  int DEPTH = 64,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire entry_type        wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output      entry_type        rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/plot_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Request sequencer: clears the store, scans it for the id and a free slot,
// then writes back at most one entry and updates the totals
module plot_ctrl import plot_pkg::*; #(
   parameter  int TABLE_DEPTH = 64,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   plot_req_if.sink              req_ch,
   input  wire logic             rsp_free,
   output logic                  rsp_load,
   output result_type            rsp_data,
   output logic                  ram_wr_en,
   output logic [IDX_W-1:0]      ram_wr_addr,
   output entry_type             ram_wr_data,
   output logic                  ram_rd_en,
   output logic [IDX_W-1:0]      ram_rd_addr,
   input  wire entry_type        ram_rd_data
);

   localparam int              CNT_W    = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_SCAN   = 5'b00100,
      S_DRAIN  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type         state_ff,     state_in;
   logic [IDX_W-1:0]  idx_ff,       idx_in;
   cmd_type           cmd_ff,       cmd_in;
   logic [ID_W-1:0]   id_ff,        id_in;
   logic [SIZE_W-1:0] size_ff,      size_in;
   logic              chk_vld_ff,   chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff,   chk_idx_in;
   logic              hit_ff,       hit_in;
   logic [IDX_W-1:0]  hit_idx_ff,   hit_idx_in;
   logic              free_ff,      free_in;
   logic [IDX_W-1:0]  free_idx_ff,  free_idx_in;
   logic [VOL_W-1:0]  mod_delta_ff, mod_delta_in;
   logic [VOL_W-1:0]  rem_delta_ff, rem_delta_in;
   logic [VOL_W-1:0]  total_ff,     total_in;
   logic [CNT_W-1:0]  count_ff,     count_in;
   status_type        status;

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      size_in      = size_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      mod_delta_in = mod_delta_ff;
      rem_delta_in = rem_delta_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      status       = ST_DONE;
      rsp_load     = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff;

      // Check the entry read in the previous cycle
      if (chk_vld_ff) begin
         if (ram_rd_data.valid && (ram_rd_data.id == id_ff)) begin
            hit_in       = 1'b1;
            hit_idx_in   = chk_idx_ff;
            mod_delta_in = size_ff - ram_rd_data.size;
            rem_delta_in = '0 - ram_rd_data.size;
         end
         if (!ram_rd_data.valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = '0;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in   = cmd_type'(req_ch.cmd);
               id_in    = req_ch.order_id;
               size_in  = req_ch.order_size;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               idx_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_ff;
            chk_vld_in  = 1'b1;
            chk_idx_in  = idx_ff;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               case (cmd_ff)
                  CMD_ADD: begin
                     if (hit_ff) begin
                        status = ST_DUP;
                     end else if (!free_ff) begin
                        status = ST_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = free_idx_ff;
                        ram_wr_data = '{valid: 1'b1, id: id_ff, size: size_ff};
                        total_in    = total_ff + size_ff;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     // empty table reports done
                     if (count_ff != '0) begin
                        if (!hit_ff) begin
                           status = ST_MISSING;
                        end else begin
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = hit_idx_ff;
                           ram_wr_data = '0;
                           total_in    = total_ff + rem_delta_ff;
                           count_in    = count_ff - CNT_W'(1);
                        end
                     end
                  end
                  CMD_MODIFY: begin
                     if (!hit_ff) begin
                        status = ST_MISSING;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = hit_idx_ff;
                        ram_wr_data = '{valid: 1'b1, id: id_ff, size: size_ff};
                        total_in    = total_ff + mod_delta_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   assign rsp_data = '{status:       status,
                       total_volume: total_in,
                       order_count:  COUNT_OUT_W'(count_in)};

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         idx_ff     <= '0;
         chk_vld_ff <= 1'b0;
         total_ff   <= '0;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         chk_vld_ff <= chk_vld_in;
         total_ff   <= total_in;
         count_ff   <= count_in;
      end
   end

   // Transaction payload and scan results
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      id_ff        <= id_in;
      size_ff      <= size_in;
      chk_idx_ff   <= chk_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      mod_delta_ff <= mod_delta_in;
      rem_delta_ff <= rem_delta_in;
   end

   // Order count never exceeds the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("order count above table depth");

   // The scan finds a free slot exactly when the counter says there is room
   a_free_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && cmd_ff == CMD_ADD && !hit_ff)
         |-> (free_ff == (count_ff != FULL_CNT)))
      else $error("free slot search disagrees with order count");

   // A write-back touches only the matched entry or a free slot
   a_writeback_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && ram_wr_en)
         |-> (hit_ff || (cmd_ff == CMD_ADD && free_ff)))
      else $error("write-back without a matching or free entry");

   // A successful add raises the count by one
   a_add_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_free && cmd_ff == CMD_ADD && !hit_ff && free_ff)
         |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("add did not increment order count");

endmodule

`default_nettype wire

### rtl/price_level_order_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Price level order table. Holds up to TABLE_DEPTH resting orders (id, size)
// of one price level and their running total volume, which wraps modulo 2^32.
// Each request transaction adds, removes or modifies one order (CMD_NONE
// changes nothing) and yields one response transaction with a status, the
// total volume and the order count. Requests are handled one at a time; the
// entry memory's single read port scans one entry per cycle for the id and a
// free slot before at most one write-back. A pending response is held in an
// output register, so the next request is accepted while it waits. After
// reset a clearing pass empties the memory; no request is accepted until it
// has finished.
module price_level_order_table import plot_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic   clock,
   input  wire logic   reset,
   plot_req_if.sink    req_ch,
   plot_rsp_if.source  rsp_ch
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic             rsp_free;
   logic             rsp_load;
   result_type       rsp_data;
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   entry_type        ram_rd_data;

   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff;

   plot_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_free    (rsp_free),
      .rsp_load    (rsp_load),
      .rsp_data    (rsp_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   plot_ram #(
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Response output register
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_data_ff.status;
   assign rsp_ch.total_volume = rsp_data_ff.total_volume;
   assign rsp_ch.order_count  = rsp_data_ff.order_count;

endmodule

`default_nettype wire

### bench/price_level_order_table_test.sv
`timescale 1ns / 1ps

module price_level_order_table_test;
   import plot_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int ID_POOL      = 96;
   localparam int EPOCH_LEN    = 150;
   localparam int EPOCHS       = 11;
   localparam int SETTLE_TICKS = 2 * (TABLE_DEPTH + 3);

   typedef enum {FILL_PHASE, MIXED_PHASE, DRAIN_PHASE} phase_type;

   typedef struct {
      cmd_type           cmd;
      logic [ID_W-1:0]   order_id;
      logic [SIZE_W-1:0] order_size;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   plot_req_if req_if ();
   plot_rsp_if rsp_if ();

   price_level_order_table uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Shadow copy of the price level
   logic              book_valid [TABLE_DEPTH];
   logic [ID_W-1:0]   book_id    [TABLE_DEPTH];
   logic [SIZE_W-1:0] book_size  [TABLE_DEPTH];
   logic [VOL_W-1:0]  book_volume;
   int unsigned       book_count;

   request_type pending_requests [$];
   result_type  expected_results [$];

   int mismatch_count = 0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   int req_gap = 0;
   bit req_gap_drawn = 1'b0;
   bit req_burst = 1'b0;
   int rsp_stall = 0;
   bit rsp_burst = 1'b0;

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic queue_request(input cmd_type c, input logic [ID_W-1:0] id,
                                input logic [SIZE_W-1:0] sz);
      request_type rq;
      rq.cmd = c;
      rq.order_id = id;
      rq.order_size = sz;
      pending_requests.insert(pending_requests.size(), rq);
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return SIZE_W'($urandom_range(1, 1000));
         default: return SIZE_W'($urandom);
      endcase
   endfunction

   // Applies one request to the shadow book and returns the response it gives
   function automatic result_type apply_order_request(input request_type rq);
      result_type res;
      int hit;
      int spare;
      hit = -1;
      spare = -1;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (book_valid[i] && book_id[i] == rq.order_id) hit = i;
         if (!book_valid[i]) spare = i;
      end
      res.status = ST_DONE;
      case (rq.cmd)
         CMD_ADD: begin
            // the duplicate check wins over the full check
            if (hit >= 0) res.status = ST_DUP;
            else if (spare < 0) res.status = ST_FULL;
            else begin
               book_valid[spare] = 1'b1;
               book_id[spare] = rq.order_id;
               book_size[spare] = rq.order_size;
               book_volume += rq.order_size;
               book_count++;
            end
         end
         CMD_REMOVE: begin
            // an empty level reports done rather than missing
            if (book_count != 0) begin
               if (hit < 0) res.status = ST_MISSING;
               else begin
                  book_volume -= book_size[hit];
                  book_valid[hit] = 1'b0;
                  book_count--;
               end
            end
         end
         CMD_MODIFY: begin
            if (hit < 0) res.status = ST_MISSING;
            else begin
               book_volume = book_volume - book_size[hit] + rq.order_size;
               book_size[hit] = rq.order_size;
            end
         end
         default: ; // unused command leaves the book alone
      endcase
      res.total_volume = book_volume;
      res.order_count = COUNT_OUT_W'(book_count);
      return res;
   endfunction

   // Request driver: next transaction at a falling edge, after a random gap, once the last one is taken
   always @(negedge clock) begin : request_driver
      request_type rq;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (!req_gap_drawn && pending_requests.size() != 0) begin
            if ($urandom_range(0, 24) == 0) req_burst = !req_burst;
            req_gap = req_burst ? 0 : $urandom_range(0, 12);
            req_gap_drawn = 1'b1;
         end
         if (req_gap > 0 || pending_requests.size() == 0) begin
            req_if.valid <= 1'b0;
            if (req_gap > 0) req_gap--;
         end else begin
            rq = pending_requests.pop_front();
            req_if.valid <= 1'b1;
            req_if.cmd <= rq.cmd;
            req_if.order_id <= rq.order_id;
            req_if.order_size <= rq.order_size;
            req_gap_drawn = 1'b0;
         end
      end
   end

   // Response sink: stall drawn per transaction, counted down while valid is up
   always @(negedge clock) begin : response_sink
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 24) == 0) rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 12);
         end
         if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            if (rsp_if.valid) rsp_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin : monitor
      request_type rq;
      result_type want;
      if (!reset && req_if.valid && req_if.ready) begin
         rq.cmd = cmd_type'(req_if.cmd);
         rq.order_id = req_if.order_id;
         rq.order_size = req_if.order_size;
         want = apply_order_request(rq);
         expected_results.insert(expected_results.size(), want);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("response with none pending: status %0d volume %0h",
                                      rsp_if.status, rsp_if.total_volume));
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_if.status, want.status));
            if (rsp_if.total_volume !== want.total_volume)
               report_mismatch($sformatf("total_volume %0h, expected %0h",
                                         rsp_if.total_volume, want.total_volume));
            if (rsp_if.order_count !== want.order_count)
               report_mismatch($sformatf("order_count %0d, expected %0d",
                                         rsp_if.order_count, want.order_count));
         end
      end
      req_taken <= !reset && req_if.valid && req_if.ready;
      rsp_taken <= !reset && rsp_if.valid && rsp_if.ready;
   end

   initial begin : stimulus
      logic [ID_W-1:0] id_pool [ID_POOL];
      request_type rq;
      phase_type kind;
      int pick;
      int add_lim;
      int remove_lim;

      req_if.valid = 1'b0;
      req_if.cmd = CMD_ADD;
      req_if.order_id = '0;
      req_if.order_size = '0;
      rsp_if.ready = 1'b0;

      for (int i = 0; i < TABLE_DEPTH; i++) begin
         book_valid[i] = 1'b0;
         book_id[i] = '0;
         book_size[i] = '0;
      end
      book_volume = '0;
      book_count = 0;

      // Directed: empty level, extremes, wrap of the total, every status but full
      queue_request(CMD_REMOVE, 32'd5, 32'hDEAD_BEEF);
      queue_request(CMD_MODIFY, 32'd5, 32'd10);
      queue_request(CMD_NONE, '1, '1);
      queue_request(CMD_ADD, '0, '1);
      queue_request(CMD_ADD, '1, 32'd1);
      queue_request(CMD_ADD, '0, 32'd7);
      queue_request(CMD_MODIFY, '1, '1);
      queue_request(CMD_MODIFY, '0, '0);
      queue_request(CMD_MODIFY, 32'h1234_5678, 32'd1);
      queue_request(CMD_REMOVE, 32'h1234_5678, '1);
      queue_request(CMD_NONE, '0, '0);
      queue_request(CMD_REMOVE, '0, 32'h5555_5555);
      queue_request(CMD_REMOVE, '1, 32'hAAAA_AAAA);
      queue_request(CMD_REMOVE, '1, '0);
      queue_request(CMD_ADD, 32'h8000_0000, 32'h8000_0000);
      queue_request(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_request(CMD_REMOVE, 32'h8000_0000, '0);
      queue_request(CMD_REMOVE, 32'h7FFF_FFFF, '0);

      // Random: phases that fill the level past full, churn it and drain it
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < ID_POOL; i++) id_pool[i] = $urandom;
      for (int e = 0; e < EPOCHS; e++) begin
         kind = phase_type'(e % 3);
         case (kind)
            FILL_PHASE: begin
               add_lim = 89;
               remove_lim = 94;
            end
            MIXED_PHASE: begin
               add_lim = 39;
               remove_lim = 70;
            end
            default: begin
               add_lim = 11;
               remove_lim = 91;
            end
         endcase
         for (int n = 0; n < EPOCH_LEN; n++) begin
            pick = $urandom_range(0, 99);
            rq.order_id = id_pool[$urandom_range(0, ID_POOL - 1)];
            rq.order_size = pick_size();
            if (pick < 4) rq.cmd = CMD_NONE;
            else if (pick < add_lim) rq.cmd = CMD_ADD;
            else if (pick < remove_lim) rq.cmd = CMD_REMOVE;
            else rq.cmd = CMD_MODIFY;
            // stray ids only on requests that cannot leave them stored
            if (rq.cmd != CMD_ADD && $urandom_range(0, 19) == 0) rq.order_id = $urandom;
            pending_requests.insert(pending_requests.size(), rq);
         end
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_if.valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #6ms;
      $display("simulation failed");
      $finish;
   end

endmodule

### price_level_order_table.f
rtl/plot_pkg.sv
rtl/plot_if.sv
rtl/plot_ram.sv
rtl/plot_ctrl.sv
rtl/price_level_order_table.sv
bench/price_level_order_table_test.sv
